@@ src/pwd_pkg.sv @@
// Shared constants, register map and types for the presence wake detector.
package pwd_pkg;

    localparam int ZONES = 16;

    // The zone tally is 5 bits wide, so it never counts past 31.
    localparam int TALLY_CAP_INT = (ZONES < 31) ? ZONES : 31;
    localparam logic [4:0] TALLY_CAP = 5'(TALLY_CAP_INT);

    localparam logic [7:0]  STATUS_OK_A = 8'd5;
    localparam logic [7:0]  STATUS_OK_B = 8'd9;
    localparam logic [16:0] ABSENT_MAX  = 17'd131071;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_MAX_DISTANCE   = 3'd0;
    localparam logic [2:0] REG_MOTION_THRESH  = 3'd1;
    localparam logic [2:0] REG_MIN_ZONES      = 3'd2;
    localparam logic [2:0] REG_STANDING       = 3'd3;
    localparam logic [2:0] REG_DECAY          = 3'd4;
    localparam logic [2:0] REG_LEAVE_TIMEOUT  = 3'd5;

    typedef struct packed {
        logic [11:0] max_distance_mm;
        logic [15:0] motion_floor;
        logic [4:0]  min_zones;
        logic [6:0]  wake_count;
        logic [7:0]  decay_step;
        logic [15:0] absence_limit_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        max_distance_mm:  12'd1500,
        motion_floor:     16'd30,
        min_zones:        5'd2,
        wake_count:       7'd15,
        decay_step:       8'd2,
        absence_limit_ms: 16'd5000
    };

endpackage

@@ src/pwd_zone_qual.sv @@
// Zone qualification test for one zone record.
module pwd_zone_qual
    import pwd_pkg::*;
(
    input  logic [11:0]        max_distance_mm,
    input  logic [15:0]        motion_floor,
    input  logic [2:0]         targets_detected,
    input  logic signed [15:0] range_mm,
    input  logic [7:0]         zone_status,
    input  logic [15:0]        motion_level,
    output logic               qualifies
);

    logic dist_ok;
    logic status_ok;

    // A positive distance fits in 15 bits, so the limit compare can be unsigned.
    assign dist_ok = !range_mm[15] && (range_mm != 16'sd0) &&
                     (range_mm[14:0] < {3'b000, max_distance_mm});

    assign status_ok = (zone_status == STATUS_OK_A) || (zone_status == STATUS_OK_B);

    assign qualifies = (targets_detected != 3'd0) && dist_ok && status_ok &&
                       (motion_level >= motion_floor);

endmodule

@@ src/presence_wake_detector.sv @@
// Top level of the presence wake detector: stream ports, register file and state update.
// Each item passes through the input register and then the result register to m_tdata.
// Throughput: one item per cycle while m_tready does not stall the result register; the input
// register and the result register each hold one item, with the combinational state update between them.
// Reset (aresetn low, synchronous) clears the tally, count, absence timer and mode,
// empties both registers and loads the register defaults; no clearing pass is needed.
module presence_wake_detector
    import pwd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    // [2:0] targets_detected, [18:3] range_mm, [26:19] zone_status,
    // [42:27] motion_level, [47:43] zero
    input  logic [47:0]       s_tdata,
    input  logic              s_tuser,    // [0] op: 0 zone record, 1 millisecond tick
    input  logic              s_tlast,    // last_zone

    output logic              m_tvalid,
    input  logic              m_tready,
    // [0] awake, [8:1] presence_count, [13:9] frame_zones, [14] woke, [15] went_to_sleep
    output logic [15:0]       m_tdata,
    output logic              m_tlast,    // frame_done

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t cfg_reg;
    logic [2:0] reg_idx;

    logic        in_vld_reg;
    logic        in_op_reg;
    logic        in_last_reg;
    logic [2:0]  in_targets_reg;
    logic [15:0] in_dist_reg;
    logic [7:0]  in_status_reg;
    logic [15:0] in_motion_reg;

    logic        out_vld_reg;
    logic [15:0] out_data_reg;
    logic        out_last_reg;

    logic [4:0]  tally_reg, tally_next;
    logic [7:0]  count_reg, count_next;
    logic [16:0] absent_reg, absent_next;
    logic        awake_reg, awake_next;

    logic        advance;
    logic        fire;
    logic        qual;
    logic [4:0]  tally_upd;
    logic        done;
    logic [4:0]  zones;
    logic        woke;
    logic        slept;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_MAX_DISTANCE:  cfg_reg.max_distance_mm  <= pwdata[11:0];
                REG_MOTION_THRESH: cfg_reg.motion_floor     <= pwdata[15:0];
                REG_MIN_ZONES:     cfg_reg.min_zones        <= pwdata[4:0];
                REG_STANDING:      cfg_reg.wake_count       <= pwdata[6:0];
                REG_DECAY:         cfg_reg.decay_step       <= pwdata[7:0];
                REG_LEAVE_TIMEOUT: cfg_reg.absence_limit_ms <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAX_DISTANCE:  prdata = {20'd0, cfg_reg.max_distance_mm};
            REG_MOTION_THRESH: prdata = {16'd0, cfg_reg.motion_floor};
            REG_MIN_ZONES:     prdata = {27'd0, cfg_reg.min_zones};
            REG_STANDING:      prdata = {25'd0, cfg_reg.wake_count};
            REG_DECAY:         prdata = {24'd0, cfg_reg.decay_step};
            REG_LEAVE_TIMEOUT: prdata = {16'd0, cfg_reg.absence_limit_ms};
            default:           prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    // The item in the input register moves on when the result register is empty or being taken.
    assign advance  = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg      <= s_tuser;
            in_last_reg    <= s_tlast;
            in_targets_reg <= s_tdata[2:0];
            in_dist_reg    <= s_tdata[18:3];
            in_status_reg  <= s_tdata[26:19];
            in_motion_reg  <= s_tdata[42:27];
        end
    end

    // ---------------- state update ----------------
    pwd_zone_qual u_qual (
        .max_distance_mm  (cfg_reg.max_distance_mm),
        .motion_floor     (cfg_reg.motion_floor),
        .targets_detected (in_targets_reg),
        .range_mm         (in_dist_reg),
        .zone_status      (in_status_reg),
        .motion_level     (in_motion_reg),
        .qualifies        (qual)
    );

    always_comb begin
        tally_next  = tally_reg;
        count_next  = count_reg;
        absent_next = absent_reg;
        awake_next  = awake_reg;
        done        = 1'b0;
        zones       = 5'd0;
        woke        = 1'b0;
        slept       = 1'b0;
        tally_upd   = tally_reg + 5'((qual && (tally_reg < TALLY_CAP)) ? 1 : 0);

        if (in_op_reg) begin
            if (absent_reg < ABSENT_MAX) begin
                absent_next = absent_reg + 17'd1;
            end
        end else begin
            tally_next = tally_upd;
            if (in_last_reg) begin
                done       = 1'b1;
                zones      = tally_upd;
                tally_next = 5'd0;
                if (tally_upd >= cfg_reg.min_zones) begin
                    if (count_reg < {cfg_reg.wake_count, 1'b0}) begin
                        count_next = count_reg + 8'd1;
                    end
                    absent_next = 17'd0;
                end else if (count_reg > cfg_reg.decay_step) begin
                    count_next = count_reg - cfg_reg.decay_step;
                end else begin
                    count_next = 8'd0;
                end
            end
        end

        // Mode check sees the count and timer as left by this item.
        if (!awake_reg) begin
            if (count_next >= {1'b0, cfg_reg.wake_count}) begin
                awake_next = 1'b1;
                woke       = 1'b1;
            end
        end else if ((count_next == 8'd0) &&
                     (absent_next > {1'b0, cfg_reg.absence_limit_ms})) begin
            awake_next = 1'b0;
            slept      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tally_reg  <= 5'd0;
            count_reg  <= 8'd0;
            absent_reg <= 17'd0;
            awake_reg  <= 1'b0;
        end else if (fire) begin
            tally_reg  <= tally_next;
            count_reg  <= count_next;
            absent_reg <= absent_next;
            awake_reg  <= awake_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {slept, woke, zones, count_next, awake_next};
            out_last_reg <= done;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
